// ===== rtl/camp_pkg.sv =====
// Shared types, fixed-point constants and helpers for the motion prediction block.
// No dependencies; every other file in rtl depends on this package.
package camp_pkg;

	localparam int DATA_W            = 32;
	localparam int DT_W              = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	localparam logic [47:0] TWO_PI_Q30 = 48'd6746518852;
	localparam logic signed [33:0] TWO_PI_S  = 34'sd6746518852;
	localparam logic signed [33:0] PI_S      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_S = 34'sd1686629713;
	localparam logic signed [33:0] GAIN_S    = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] turn_rate;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic [15:0]        delta_t;
	} item_t;

	typedef struct packed {
		logic signed [31:0] next_pos_x;
		logic signed [31:0] next_pos_y;
		logic signed [31:0] next_heading;
		logic signed [31:0] next_vel_x;
		logic signed [31:0] next_vel_y;
		logic signed [31:0] next_turn_rate;
		logic signed [31:0] next_acc_x;
		logic signed [31:0] next_acc_y;
		logic signed [31:0] d_posx_d_heading;
		logic signed [31:0] d_posy_d_heading;
		logic signed [31:0] d_velx_d_heading;
		logic signed [31:0] d_vely_d_heading;
	} result_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] v;
		case (i)
			0:       v = 34'sd843314857;
			1:       v = 34'sd497837830;
			2:       v = 34'sd263043837;
			3:       v = 34'sd133525159;
			4:       v = 34'sd67021687;
			5:       v = 34'sd33543516;
			6:       v = 34'sd16775852;
			7:       v = 34'sd8388437;
			8:       v = 34'sd4194283;
			9:       v = 34'sd2097149;
			default: v = 34'sd1 <<< (30 - i);
		endcase
		return v;
	endfunction

	// Clamp a wide signed sum into the signed output range.
	function automatic logic signed [31:0] sat(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			r = 32'sh80000000;
		else
			r = 32'(v);
		return r;
	endfunction

endpackage

// ===== rtl/camp_pipe.sv =====
// Datapath pipeline: squares and square root, heading reduction, CORDIC, products, sums.
// Depends on camp_pkg. All stages advance together on en.
module camp_pipe #(
	parameter int CORDIC_STAGES = camp_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              item_valid,
	input  camp_pkg::item_t   item,
	output logic              last_valid,
	output camp_pkg::result_t last_result
);
	import camp_pkg::*;

	localparam int NC     = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
	localparam int SQ_END = 34;
	localparam int CD_END = 18 + NC;
	localparam int P      = (SQ_END > CD_END) ? SQ_END : CD_END;
	localparam int NS     = P + 3;

	typedef struct packed {
		item_t              item;
		logic [63:0]        sqx;
		logic [63:0]        sqy;
		logic [63:0]        n;
		logic [63:0]        res;
		logic [47:0]        m;
		logic               rneg;
		logic signed [33:0] ang;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic               neg;
		logic signed [33:0] cs;
		logic signed [33:0] sn;
		logic signed [48:0] adtx;
		logic signed [48:0] adty;
		logic signed [48:0] wdt;
		logic signed [66:0] pc;
		logic signed [66:0] ps;
		logic signed [65:0] adt2x;
		logic signed [65:0] adt2y;
		logic signed [35:0] vc;
		logic signed [35:0] vs;
		logic signed [52:0] vcdt;
		logic signed [52:0] vsdt;
	} stage_t;

	function automatic stage_t step(input int j, input stage_t s);
		stage_t             o;
		logic [31:0]        mx;
		logic [31:0]        my;
		logic signed [47:0] r;
		logic [47:0]        lim;
		logic [63:0]        bitv;
		logic [63:0]        t;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [16:0] dts;
		logic signed [32:0] spd;
		logic signed [35:0] vcw;
		logic signed [35:0] vsw;
		o   = s;
		dts = $signed({1'b0, s.item.delta_t});
		spd = $signed({1'b0, s.res[31:0]});
		if (j == 1) begin
			mx     = s.item.vel_x[31] ? 32'(-s.item.vel_x) : 32'(s.item.vel_x);
			my     = s.item.vel_y[31] ? 32'(-s.item.vel_y) : 32'(s.item.vel_y);
			o.sqx  = 64'(mx) * 64'(mx);
			o.sqy  = 64'(my) * 64'(my);
			r      = {{2{s.item.heading[31]}}, s.item.heading, 14'd0};
			o.rneg = r[47];
			o.m    = r[47] ? 48'(-r) : 48'(r);
			o.res  = '0;
		end
		if (j == 2)
			o.n = s.sqx + s.sqy;
		// Exact reduction of the heading magnitude modulo two pi.
		if (j >= 2 && j <= 15) begin
			lim = TWO_PI_Q30 << (15 - j);
			if (s.m >= lim)
				o.m = s.m - lim;
		end
		// One result bit of the floor square root per stage.
		if (j >= 3 && j <= SQ_END) begin
			bitv = 64'd1 << (2 * (SQ_END - j));
			t    = s.res + bitv;
			if (s.n >= t) begin
				o.n   = s.n - t;
				o.res = (s.res >> 1) + bitv;
			end else begin
				o.res = s.res >> 1;
			end
		end
		if (j == 16)
			o.ang = (s.rneg && s.m != '0) ? 34'(TWO_PI_Q30 - s.m) : 34'(s.m);
		if (j == 17 && s.ang > PI_S)
			o.ang = s.ang - TWO_PI_S;
		if (j == 18) begin
			o.x   = GAIN_S;
			o.y   = '0;
			o.neg = 1'b0;
			if (s.ang > HALF_PI_S) begin
				o.ang = s.ang - PI_S;
				o.neg = 1'b1;
			end else if (s.ang < -HALF_PI_S) begin
				o.ang = s.ang + PI_S;
				o.neg = 1'b1;
			end
		end
		if (j >= 19 && j <= CD_END) begin
			dx = s.y >>> (j - 19);
			dy = s.x >>> (j - 19);
			if (s.ang >= 0) begin
				o.x   = s.x - dx;
				o.y   = s.y + dy;
				o.ang = s.ang - atan_q30(j - 19);
			end else begin
				o.x   = s.x + dx;
				o.y   = s.y - dy;
				o.ang = s.ang + atan_q30(j - 19);
			end
		end
		if (j == P + 1) begin
			o.cs   = s.neg ? -s.x : s.x;
			o.sn   = s.neg ? -s.y : s.y;
			o.adtx = s.item.acc_x * dts;
			o.adty = s.item.acc_y * dts;
			o.wdt  = s.item.turn_rate * dts;
		end
		if (j == P + 2) begin
			o.pc    = spd * s.cs;
			o.ps    = spd * s.sn;
			o.adt2x = s.adtx * dts;
			o.adt2y = s.adty * dts;
		end
		if (j == P + 3) begin
			vcw    = 36'(s.pc >>> 30);
			vsw    = 36'(s.ps >>> 30);
			o.vc   = vcw;
			o.vs   = vsw;
			o.vcdt = vcw * dts;
			o.vsdt = vsw * dts;
		end
		return o;
	endfunction

	stage_t st0;
	stage_t st  [1:NS];
	stage_t nxt [1:NS];
	logic   vld_s [1:NS];

	always_comb begin
		st0      = '0;
		st0.item = item;
	end

	for (genvar j = 1; j <= NS; j++) begin : g_stg
		if (j == 1) begin : g_first
			always_comb nxt[j] = step(j, st0);
		end else begin : g_rest
			always_comb nxt[j] = step(j, st[j-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= NS; j++)
				vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= item_valid;
			for (int j = 2; j <= NS; j++)
				vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			for (int j = 1; j <= NS; j++)
				st[j] <= nxt[j];
	end

	// Final sums and saturation on the last stage.
	logic signed [39:0] vcdt16, vsdt16, axdt16, aydt16, hx, hy, wdt16, vc40, vs40;

	always_comb begin
		vcdt16 = 40'(st[NS].vcdt >>> 16);
		vsdt16 = 40'(st[NS].vsdt >>> 16);
		axdt16 = 40'(st[NS].adtx >>> 16);
		aydt16 = 40'(st[NS].adty >>> 16);
		hx     = 40'(st[NS].adt2x >>> 33);
		hy     = 40'(st[NS].adt2y >>> 33);
		wdt16  = 40'(st[NS].wdt >>> 16);
		vc40   = 40'(st[NS].vc);
		vs40   = 40'(st[NS].vs);
		last_result.next_pos_x       = sat(40'(st[NS].item.pos_x) + vcdt16 + hx);
		last_result.next_pos_y       = sat(40'(st[NS].item.pos_y) + vsdt16 + hy);
		last_result.next_heading     = sat(40'(st[NS].item.heading) + wdt16);
		last_result.next_vel_x       = sat(vc40 + axdt16);
		last_result.next_vel_y       = sat(vs40 + aydt16);
		last_result.next_turn_rate   = st[NS].item.turn_rate;
		last_result.next_acc_x       = st[NS].item.acc_x;
		last_result.next_acc_y       = st[NS].item.acc_y;
		last_result.d_posx_d_heading = sat(-vsdt16);
		last_result.d_posy_d_heading = sat(vcdt16);
		last_result.d_velx_d_heading = sat(-vs40);
		last_result.d_vely_d_heading = sat(vc40);
	end

	assign last_valid = vld_s[NS];

endmodule

// ===== rtl/const_accel_motion_predict_unit.sv =====
// Top level of the constant-acceleration motion prediction block.
// Depends on camp_pkg and camp_pipe.
//
// This block takes one tracked-object state per cycle while item_ready is high and
// returns one prediction per transfer, at a sustained rate of one item per clock while
// results are accepted. The pipeline depth is set by the 32-step pipelined square root
// that produces speed (or by the CORDIC chain if more than the default sixteen stages
// are configured), followed by the multiplier stages. A one-entry skid register behind
// the output register lets the pipeline retire one more item while a result waits;
// item_ready falls only when both are occupied and never depends combinationally on
// result_ready.
module const_accel_motion_predict_unit #(
	parameter int CORDIC_STAGES = camp_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  camp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output camp_pkg::result_t result
);
	import camp_pkg::*;

	logic    en;
	logic    last_valid;
	result_t last_result;
	logic    skid_v_q;
	result_t skid_q;
	result_t out_q;
	logic    out_v_q;

	// The whole pipeline moves whenever the skid entry is free.
	assign en         = !skid_v_q;
	assign item_ready = en;

	camp_pipe #(.CORDIC_STAGES(CORDIC_STAGES)) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.item_valid  (item_valid),
		.item        (item),
		.last_valid  (last_valid),
		.last_result (last_result)
	);

	// Control of the output register and the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !result_ready) begin
			if (en && last_valid)
				skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= en && last_valid;
		end
	end

	// Payload moves under the same conditions, with no reset.
	always_ff @(posedge clk) begin
		if (out_v_q && !result_ready) begin
			if (en && last_valid)
				skid_q <= last_result;
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (en && last_valid) begin
			out_q <= last_result;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

// ===== rtl/camp_checker.sv =====
// Port-level checks for const_accel_motion_predict_unit, attached by bind.
// Depends on camp_pkg for the result type.
module camp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input camp_pkg::result_t result
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Input back-pressure only starts after an output stall.
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_ready) |-> $past(result_valid && !result_ready))
		else $error("item_ready fell without an output stall");

	// Back-pressure means a result is being offered.
	a_bp_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("item_ready low with no result offered");

	// Back-pressure clears only once the offered result is taken.
	a_bp_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_ready) |-> $past(result_valid && result_ready))
		else $error("item_ready rose without an output transfer");

endmodule

bind const_accel_motion_predict_unit camp_checker u_camp_checker (.*);
